// ----- hw/rtl/csw_pkg.sv -----
package csw_pkg;

   localparam int CMD_W    = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 17;
   localparam int INIT_W   = 15;
   localparam int MAXW_W   = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 15;

   localparam logic [CMD_W-1:0] CMD_WAIT    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TRYWAIT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SIGNAL  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_PROCEED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TRYFAIL = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_COUNT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_WAITERS   = 1'd1;

   localparam logic signed [COUNT_W-1:0] COUNT_TOP  = 17'sd65535;
   localparam logic [MAXW_W-1:0]         MAXW_RESET = 5'd16;

   typedef logic signed [COUNT_W-1:0] count_type;

endpackage

// ----- hw/rtl/csw_req_if.sv -----
interface csw_req_if #(
   parameter int TASK_ID_BITS = 8
);
   logic                          valid;
   logic                          ready;
   logic [csw_pkg::CMD_W-1:0]     cmd;
   logic [TASK_ID_BITS-1:0]       task_id;

   modport source (output valid, output cmd, output task_id, input ready);
   modport sink   (input valid, input cmd, input task_id, output ready);
endinterface

// ----- hw/rtl/csw_rsp_if.sv -----
interface csw_rsp_if #(
   parameter int TASK_ID_BITS = 8,
   parameter int QUEUE_DEPTH  = 16
);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic                          valid;
   logic                          ready;
   logic [csw_pkg::STATUS_W-1:0]  status;
   logic                          woken_valid;
   logic [TASK_ID_BITS-1:0]       woken_task;
   csw_pkg::count_type            count_now;
   logic [FILL_W-1:0]             waiters_now;

   modport source (output valid, output status, output woken_valid, output woken_task,
                   output count_now, output waiters_now, input ready);
   modport sink   (input valid, input status, input woken_valid, input woken_task,
                   input count_now, input waiters_now, output ready);
endinterface

// ----- hw/rtl/csw_queue_ram.sv -----
module csw_queue_ram #(
   parameter int DEPTH  = 16,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/counting_semaphore_wait_queue_core.sv -----
// Counting semaphore with a FIFO queue of blocked task IDs.
// req_if carries one operation per item (cmd: wait, trywait, signal, plus
// task_id); rsp_if returns exactly one result item per operation with the
// status, the released task on a wake-up, and the count and queue fill after
// the operation. csr_we/csr_idx/csr_wdata write initial_count (reloads the
// count, empties the queue) and max_waiters; write only while idle.
// The result is registered and valid the cycle after the request is accepted.
// Throughput: one item per cycle when not stalled. The count and queue
// pointers update in the accept cycle; the queue RAM is read at the head
// pointer in that same cycle and its registered read port feeds woken_task.
// A stalled receiver holds the result register; req_if.ready stays low until
// the pending result is taken or is taken in the same cycle.
// Reset (synchronous, active high): count 0, queue empty, max_waiters 16,
// no result pending. Queue entries are not cleared; an entry is only
// reported as woken_task after it has been written.
module counting_semaphore_wait_queue_core #(
   parameter int QUEUE_DEPTH  = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   csw_req_if.sink                            req_if,
   csw_rsp_if.source                          rsp_if,
   input  logic                               csr_we,
   input  logic [csw_pkg::CSR_IDX_W-1:0]      csr_idx,
   input  logic [csw_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LIM_W  = (FILL_W > csw_pkg::MAXW_W) ? FILL_W : csw_pkg::MAXW_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [LIM_W-1:0] DEPTH_LIM = LIM_W'(QUEUE_DEPTH);

   csw_pkg::count_type                count_ff, count_in;
   logic [PTR_W-1:0]                  head_ff, head_in;
   logic [PTR_W-1:0]                  tail_ff, tail_in;
   logic [FILL_W-1:0]                 fill_ff, fill_in;
   logic [csw_pkg::MAXW_W-1:0]        max_waiters_ff, max_waiters_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [csw_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic                              rsp_woken_ff, rsp_woken_in;
   csw_pkg::count_type                rsp_count_ff;
   logic [FILL_W-1:0]                 rsp_fill_ff;

   logic                              accept;
   logic                              push;
   logic                              pop;
   logic [LIM_W-1:0]                  limit;
   logic                              queue_full;
   logic                              count_le_zero;
   logic [TASK_ID_BITS-1:0]           rd_data;

   csw_pkg::count_type                op_count;
   logic [csw_pkg::STATUS_W-1:0]      op_status;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   assign limit = (LIM_W'(max_waiters_ff) > DEPTH_LIM) ? DEPTH_LIM : LIM_W'(max_waiters_ff);
   assign queue_full    = LIM_W'(fill_ff) >= limit;
   assign count_le_zero = count_ff[csw_pkg::COUNT_W-1] || (count_ff == '0);

   always_comb begin
      op_count  = count_ff;
      op_status = csw_pkg::ST_PROCEED;
      push      = 1'b0;
      pop       = 1'b0;
      unique case (req_if.cmd)
         csw_pkg::CMD_WAIT: begin
            if (count_le_zero) begin
               if (queue_full) begin
                  op_status = csw_pkg::ST_ERROR;
               end else begin
                  push      = 1'b1;
                  op_count  = count_ff - 17'sd1;
                  op_status = csw_pkg::ST_BLOCKED;
               end
            end else begin
               op_count = count_ff - 17'sd1;
            end
         end
         csw_pkg::CMD_TRYWAIT: begin
            if (count_le_zero) begin
               op_status = csw_pkg::ST_TRYFAIL;
            end else begin
               op_count = count_ff - 17'sd1;
            end
         end
         csw_pkg::CMD_SIGNAL: begin
            if (count_ff[csw_pkg::COUNT_W-1]) begin
               if (fill_ff == '0) begin
                  op_status = csw_pkg::ST_ERROR;
               end else begin
                  pop      = 1'b1;
                  op_count = count_ff + 17'sd1;
               end
            end else if (count_ff != csw_pkg::COUNT_TOP) begin
               op_count = count_ff + 17'sd1;
            end
         end
         default: begin
            op_status = csw_pkg::ST_ERROR;
         end
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      fill_in        = fill_ff;
      max_waiters_in = max_waiters_ff;
      if (csr_we) begin
         unique case (csr_idx)
            csw_pkg::CSR_INITIAL_COUNT: begin
               count_in = csw_pkg::count_type'({2'b00, csr_wdata[csw_pkg::INIT_W-1:0]});
               head_in  = '0;
               tail_in  = '0;
               fill_in  = '0;
            end
            csw_pkg::CSR_MAX_WAITERS: begin
               max_waiters_in = csr_wdata[csw_pkg::MAXW_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         count_in = op_count;
         if (push) begin
            tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
            fill_in = fill_ff + FILL_W'(1);
         end
         if (pop) begin
            head_in = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
            fill_in = fill_ff - FILL_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_woken_in  = rsp_woken_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = op_status;
         rsp_woken_in  = pop;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         head_ff        <= '0;
         tail_ff        <= '0;
         fill_ff        <= '0;
         max_waiters_ff <= csw_pkg::MAXW_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         count_ff       <= count_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         fill_ff        <= fill_in;
         max_waiters_ff <= max_waiters_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_woken_ff  <= rsp_woken_in;
      if (accept) begin
         rsp_count_ff <= op_count;
         rsp_fill_ff  <= fill_in;
      end
   end

   csw_queue_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .WIDTH  (TASK_ID_BITS),
      .ADDR_W (PTR_W)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (accept && push && !csr_we),
      .wr_addr (tail_ff),
      .wr_data (req_if.task_id),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.woken_valid = rsp_woken_ff;
   assign rsp_if.woken_task  = rsp_woken_ff ? rd_data : '0;
   assign rsp_if.count_now   = rsp_count_ff;
   assign rsp_if.waiters_now = rsp_fill_ff;

endmodule

// ----- dv/tb_counting_semaphore_wait_queue_core.sv -----
`timescale 1ns / 1ps

module tb_counting_semaphore_wait_queue_core;
   import csw_pkg::*;

   localparam int QUEUE_DEPTH   = 16;
   localparam int TASK_ID_BITS  = 8;
   localparam int QUIET_LIMIT   = 1000;
   localparam int HOLD_CYCLES   = 80;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_ITEMS   = 46;
   localparam int CLIMB_ITEMS   = 40;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic                    woken_valid;
      logic [TASK_ID_BITS-1:0] woken_task;
      logic [COUNT_W-1:0]      count_now;
      logic [4:0]              waiters_now;
   } sem_result_type;

   typedef struct {
      bit                      is_csr;
      logic [CSR_IDX_W-1:0]    idx;
      logic [CSR_DATA_W-1:0]   data;
      logic [CMD_W-1:0]        op;
      logic [TASK_ID_BITS-1:0] id;
      bit                      typed;
      sem_result_type          res;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_idx;
   logic [CSR_DATA_W-1:0] csr_wdata;

   csw_req_if #(.TASK_ID_BITS(TASK_ID_BITS)) req_bus ();
   csw_rsp_if #(.TASK_ID_BITS(TASK_ID_BITS), .QUEUE_DEPTH(QUEUE_DEPTH)) rsp_bus ();

   counting_semaphore_wait_queue_core #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TASK_ID_BITS(TASK_ID_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_bus),
      .rsp_if   (rsp_bus),
      .csr_we   (csr_we),
      .csr_idx  (csr_idx),
      .csr_wdata(csr_wdata)
   );

   int                      sem_count = 0;
   int                      waiter_cap = 16;
   logic [TASK_ID_BITS-1:0] waiting_ids[$];
   sem_result_type          pending_results[$];
   plan_row_type            plan[$];
   int                      fail_count = 0;
   int                      quiet_cycles = 0;
   bit                      tx_idle_en = 1'b1;
   bit                      rx_idle_en = 1'b1;
   bit                      hold_off_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sem_result_type apply_operation(logic [CMD_W-1:0] op,
                                                      logic [TASK_ID_BITS-1:0] id);
      sem_result_type r;
      int             limit;
      int             nxt;
      r = '0;
      limit = (waiter_cap > QUEUE_DEPTH) ? QUEUE_DEPTH : waiter_cap;
      case (op)
         CMD_WAIT: begin
            nxt = sem_count - 1;
            if (nxt < 0) begin
               if (waiting_ids.size() >= limit) begin
                  r.status = ST_ERROR;
               end else begin
                  waiting_ids.push_back(id);
                  sem_count = nxt;
                  r.status = ST_BLOCKED;
               end
            end else begin
               sem_count = nxt;
            end
         end
         CMD_TRYWAIT: begin
            if (sem_count <= 0) r.status = ST_TRYFAIL;
            else sem_count = sem_count - 1;
         end
         CMD_SIGNAL: begin
            nxt = (sem_count >= int'(COUNT_TOP)) ? int'(COUNT_TOP) : sem_count + 1;
            if (nxt <= 0) begin
               if (waiting_ids.size() == 0) begin
                  r.status = ST_ERROR;
               end else begin
                  r.woken_valid = 1'b1;
                  r.woken_task = waiting_ids.pop_front();
                  sem_count = nxt;
               end
            end else begin
               sem_count = nxt;
            end
         end
         default: begin
            r.status = ST_ERROR;
         end
      endcase
      r.count_now = sem_count[COUNT_W-1:0];
      r.waiters_now = 5'(waiting_ids.size());
      return r;
   endfunction

   function automatic plan_row_type op_row(logic [CMD_W-1:0] op,
                                           logic [TASK_ID_BITS-1:0] id);
      plan_row_type r;
      r.is_csr = 1'b0;
      r.idx = '0;
      r.data = '0;
      r.op = op;
      r.id = id;
      r.typed = 1'b0;
      r.res = '0;
      return r;
   endfunction

   function automatic plan_row_type chk_row(logic [CMD_W-1:0] op, logic [TASK_ID_BITS-1:0] id,
                                            logic [STATUS_W-1:0] st, logic wv,
                                            logic [TASK_ID_BITS-1:0] wt, int cnt, int fill);
      plan_row_type r;
      r = op_row(op, id);
      r.typed = 1'b1;
      r.res.status = st;
      r.res.woken_valid = wv;
      r.res.woken_task = wt;
      r.res.count_now = cnt[COUNT_W-1:0];
      r.res.waiters_now = fill[4:0];
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IDX_W-1:0] idx,
                                            logic [CSR_DATA_W-1:0] data);
      plan_row_type r;
      r = op_row(CMD_WAIT, '0);
      r.is_csr = 1'b1;
      r.idx = idx;
      r.data = data;
      return r;
   endfunction

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) $display("mismatch: %s", msg);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_we <= 1'b1;
      csr_idx <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_INITIAL_COUNT) begin
         sem_count = int'(data);
         waiting_ids.delete();
      end else begin
         waiter_cap = int'(data[MAXW_W-1:0]);
      end
      @(posedge clock);
   endtask

   task automatic send_op(logic [CMD_W-1:0] op, logic [TASK_ID_BITS-1:0] id,
                          bit typed, sem_result_type typed_res);
      sem_result_type want;
      want = apply_operation(op, id);
      pending_results.push_back(typed ? typed_res : want);
      while (tx_idle_en && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= op;
      req_bus.task_id <= id;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_bus.ready <= !(rx_idle_en && $urandom_range(99) < 23);
         end
      end
   end

   always @(posedge clock) begin
      sem_result_type want;
      sem_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = {rsp_bus.status, rsp_bus.woken_valid, rsp_bus.woken_task,
                rsp_bus.count_now, rsp_bus.waiters_now};
         if (pending_results.size() == 0) begin
            note_failure($sformatf("unexpected item: status %0d count %0d waiters %0d",
                                   got.status, $signed(got.count_now), got.waiters_now));
         end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status || got.woken_valid !== want.woken_valid ||
                got.woken_task !== want.woken_task || got.count_now !== want.count_now ||
                got.waiters_now !== want.waiters_now) begin
               note_failure($sformatf(
                  "exp st %0d wk %0d/%02h cnt %0d wt %0d, got st %0d wk %0d/%02h cnt %0d wt %0d",
                  want.status, want.woken_valid, want.woken_task, $signed(want.count_now),
                  want.waiters_now, got.status, got.woken_valid, got.woken_task,
                  $signed(got.count_now), got.waiters_now));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int               pick;
      int               wait_pct;
      logic [CMD_W-1:0] op;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.cmd <= CMD_WAIT;
      req_bus.task_id <= '0;
      csr_we <= 1'b0;
      csr_idx <= CSR_INITIAL_COUNT;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      plan.push_back(chk_row(CMD_TRYWAIT, 8'h00, ST_TRYFAIL, 1'b0, 8'h00, 0, 0));
      plan.push_back(chk_row(CMD_SIGNAL,  8'hFF, ST_PROCEED, 1'b0, 8'h00, 1, 0));
      plan.push_back(chk_row(CMD_WAIT,    8'hAA, ST_PROCEED, 1'b0, 8'h00, 0, 0));
      plan.push_back(chk_row(CMD_WAIT,    8'h55, ST_BLOCKED, 1'b0, 8'h00, -1, 1));
      plan.push_back(chk_row(CMD_WAIT,    8'hFF, ST_BLOCKED, 1'b0, 8'h00, -2, 2));
      plan.push_back(chk_row(CMD_UNUSED,  8'h12, ST_ERROR,   1'b0, 8'h00, -2, 2));
      plan.push_back(chk_row(CMD_TRYWAIT, 8'h01, ST_TRYFAIL, 1'b0, 8'h00, -2, 2));
      plan.push_back(chk_row(CMD_SIGNAL,  8'h00, ST_PROCEED, 1'b1, 8'h55, -1, 1));
      plan.push_back(op_row(CMD_SIGNAL, 8'h80));
      // no waiters allowed
      plan.push_back(csr_row(CSR_MAX_WAITERS, 15'd0));
      plan.push_back(chk_row(CMD_WAIT,    8'h01, ST_ERROR,   1'b0, 8'h00, 0, 0));
      plan.push_back(csr_row(CSR_MAX_WAITERS, 15'd1));
      plan.push_back(chk_row(CMD_WAIT,    8'h00, ST_BLOCKED, 1'b0, 8'h00, -1, 1));
      plan.push_back(chk_row(CMD_WAIT,    8'h02, ST_ERROR,   1'b0, 8'h00, -1, 1));
      // cap above queue depth, then lowered below the fill
      plan.push_back(csr_row(CSR_MAX_WAITERS, 15'd31));
      plan.push_back(op_row(CMD_WAIT, 8'h80));
      plan.push_back(csr_row(CSR_MAX_WAITERS, 15'd1));
      plan.push_back(chk_row(CMD_WAIT,    8'h7F, ST_ERROR,   1'b0, 8'h00, -2, 2));
      plan.push_back(op_row(CMD_SIGNAL, 8'h3C));
      plan.push_back(op_row(CMD_SIGNAL, 8'hC3));
      plan.push_back(op_row(CMD_WAIT, 8'h33));
      // reload with a waiter queued
      plan.push_back(csr_row(CSR_INITIAL_COUNT, 15'h7FFF));
      plan.push_back(chk_row(CMD_TRYWAIT, 8'h00, ST_PROCEED, 1'b0, 8'h00, 32766, 0));
      plan.push_back(op_row(CMD_SIGNAL, 8'h01));

      foreach (plan[i]) begin
         if (plan[i].is_csr) write_csr(plan[i].idx, plan[i].data);
         else send_op(plan[i].op, plan[i].id, plan[i].typed, plan[i].res);
      end

      // climb past the initial_count range, no idling on either side
      write_csr(CSR_MAX_WAITERS, 15'(MAXW_RESET));
      write_csr(CSR_INITIAL_COUNT, 15'h7FFF);
      tx_idle_en = 1'b0;
      rx_idle_en = 1'b0;
      repeat (CLIMB_ITEMS) send_op(CMD_SIGNAL, 8'($urandom), 1'b0, '0);
      send_op(CMD_TRYWAIT, 8'($urandom), 1'b0, '0);
      send_op(CMD_WAIT, 8'($urandom), 1'b0, '0);
      tx_idle_en = 1'b1;
      rx_idle_en = 1'b1;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         pick = $urandom_range(4);
         case (pick)
            0: write_csr(CSR_MAX_WAITERS, 15'd0);
            1: write_csr(CSR_MAX_WAITERS, 15'd1);
            2: write_csr(CSR_MAX_WAITERS, 15'($urandom_range(31, 17)));
            3: write_csr(CSR_MAX_WAITERS, 15'(MAXW_RESET));
            default: write_csr(CSR_MAX_WAITERS, 15'($urandom_range(16, 1)));
         endcase
         pick = $urandom_range(9);
         if (pick <= 5) write_csr(CSR_INITIAL_COUNT, 15'($urandom_range(3)));
         else if (pick <= 7) write_csr(CSR_INITIAL_COUNT, 15'($urandom));
         else if (pick == 8) write_csr(CSR_INITIAL_COUNT, 15'h7FFF);
         else write_csr(CSR_INITIAL_COUNT, 15'd0);
         if (p == 2) hold_off_req = 1'b1;
         wait_pct = (p % 2) ? 50 : 35;
         repeat (PHASE_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < wait_pct) op = CMD_WAIT;
            else if (pick < wait_pct + 15) op = CMD_TRYWAIT;
            else if (pick < 95) op = CMD_SIGNAL;
            else op = CMD_UNUSED;
            send_op(op, 8'($urandom), 1'b0, '0);
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/csw_pkg.sv
hw/rtl/csw_req_if.sv
hw/rtl/csw_rsp_if.sv
hw/rtl/csw_queue_ram.sv
hw/rtl/counting_semaphore_wait_queue_core.sv
dv/tb_counting_semaphore_wait_queue_core.sv
